// ----- hw/rtl/vdts_pkg.sv -----
// ----------------------------------------------------------------------------
// vdts_pkg
// Types and constants shared by the value density task scheduler.
// ----------------------------------------------------------------------------
package vdts_pkg;

    localparam logic [16:0] PRIO_SCALE = 17'd100000;
    localparam logic [11:0] VAL_MAX    = 12'hfff;
    localparam logic [15:0] LATE_MAX   = 16'hffff;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_FREE = 2'd0,
        ST_WAIT = 2'd1,
        ST_RUN  = 2'd2
    } t_slot_st;

    typedef struct packed {
        logic        req_type;
        logic [11:0] task_value;
        logic [11:0] exec_time;
        logic [31:0] deadline;
    } t_req;

    typedef struct packed {
        logic        accepted;
        logic [3:0]  add_slot;
        logic        ran;
        logic [3:0]  run_slot;
        logic        preempted;
        logic        completed;
        logic [11:0] delivered_value;
        logic [15:0] lateness;
        logic [15:0] missed_mask;
    } t_rsp;

    // divider handshake
    typedef struct packed {
        logic        start;
        logic [11:0] val;
        logic [11:0] rem;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [28:0] quo;
    } t_div_rsp;

endpackage

// ----- hw/rtl/value_density_task_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// value_density_task_scheduler_core
// Preemptive value density scheduler over a table of task slots.
// ----------------------------------------------------------------------------
//  channel | direction | ports                 | beat
//  request | in        | i_start, i_req        | i_start && !o_busy
//  result  | out       | o_done, o_rsp         | o_done, one cycle
//
//  add: scan up to SLOTS slots, then one priority divide if a slot is free.
//  tick: aging pass over SLOTS slots with a divide per late waiting task,
//  a selection pass over SLOTS slots, a run step and up to one divide.
//  the add, aging and run steps share the one divider.
//  reset is synchronous and clears slot status and the tick counter.
//  the result cannot be stalled; o_busy is low once it is shown.
// ----------------------------------------------------------------------------
module value_density_task_scheduler_core
    import vdts_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    output logic o_busy,
    output logic o_done,
    output t_rsp o_rsp
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_ADDSC = 10'b0000000010,
        S_AGE   = 10'b0000000100,
        S_AGEDV = 10'b0000001000,
        S_SEL   = 10'b0000010000,
        S_PRE   = 10'b0000100000,
        S_RUN   = 10'b0001000000,
        S_RUNDV = 10'b0010000000,
        S_ADDDV = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_st;

    t_st r_st, n_st;

    t_slot_st    r_stat [SLOTS];
    logic [11:0] r_cur  [SLOTS];
    logic [11:0] r_kept [SLOTS];
    logic [11:0] r_rem  [SLOTS];
    logic [31:0] r_due  [SLOTS];
    logic [15:0] r_late [SLOTS];
    logic [28:0] r_prio [SLOTS];
    logic [31:0] r_now;

    logic [SW-1:0] r_idx;
    logic          r_found;
    logic [SW-1:0] r_best;
    logic [28:0]   r_bprio;
    t_req          r_req;
    t_rsp          r_rsp;
    logic          r_done;
    logic          r_divgo;

    t_div_req w_dreq;
    t_div_rsp w_drsp;

    logic          w_last;
    logic          w_late;
    logic [11:0]   w_len;
    logic [11:0]   w_cdec;
    logic [11:0]   w_cinc;

    vdts_density u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    assign w_last = (r_idx == SW'(SLOTS - 1));
    assign w_late = (r_now > r_due[r_idx]);
    assign w_len  = (r_req.exec_time == 12'd0) ? 12'd1 : r_req.exec_time;
    assign w_cdec = (r_cur[r_idx] != 12'd0) ? r_cur[r_idx] - 12'd1 : 12'd0;
    assign w_cinc = (r_cur[r_best] != VAL_MAX) ? r_cur[r_best] + 12'd1 : VAL_MAX;

    always_comb begin
        w_dreq.start = r_divgo;
        w_dreq.val   = (r_st == S_RUNDV) ? r_cur[r_best] : r_cur[r_idx];
        // run step already counted down; divide on the count before it
        w_dreq.rem   = (r_st == S_RUNDV) ? r_rem[r_best] + 12'd1 : r_rem[r_idx];
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE:  n_st = i_start ? (i_req.req_type == REQ_TICK ? S_AGE : S_ADDSC) : S_IDLE;
            S_ADDSC: n_st = (r_stat[r_idx] == ST_FREE) ? S_ADDDV : (w_last ? S_OUT : S_ADDSC);
            S_ADDDV: n_st = w_drsp.done ? S_OUT : S_ADDDV;
            S_AGE: begin
                if (r_stat[r_idx] != ST_FREE && w_late && r_stat[r_idx] == ST_WAIT) begin
                    n_st = S_AGEDV;
                end else if (w_last) begin
                    n_st = S_SEL;
                end
            end
            S_AGEDV: n_st = w_drsp.done ? (w_last ? S_SEL : S_AGE) : S_AGEDV;
            S_SEL:   n_st = w_last ? S_PRE : S_SEL;
            S_PRE:   n_st = r_found ? S_RUN : S_OUT;
            S_RUN:   n_st = (r_late[r_best] != 16'd0) ? S_RUNDV : S_OUT;
            S_RUNDV: n_st = w_drsp.done ? S_OUT : S_RUNDV;
            S_OUT:   n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_now   <= '0;
            r_done  <= 1'b0;
            r_divgo <= 1'b0;
            for (int s = 0; s < SLOTS; s++) begin
                r_stat[s] <= ST_FREE;
            end
        end else begin
            r_st    <= n_st;
            r_done  <= 1'b0;
            r_divgo <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_start) begin
                        r_req   <= i_req;
                        r_rsp   <= '0;
                        r_idx   <= '0;
                        r_found <= 1'b0;
                    end
                end
                S_ADDSC: begin
                    if (r_stat[r_idx] == ST_FREE) begin
                        r_stat[r_idx]    <= ST_WAIT;
                        r_cur[r_idx]     <= r_req.task_value;
                        r_kept[r_idx]    <= r_req.task_value;
                        r_rem[r_idx]     <= w_len;
                        r_due[r_idx]     <= r_req.deadline;
                        r_late[r_idx]    <= '0;
                        r_rsp.accepted   <= 1'b1;
                        r_rsp.add_slot   <= 4'(r_idx);
                        r_divgo          <= 1'b1;
                    end else if (!w_last) begin
                        r_idx <= r_idx + SW'(1);
                    end
                end
                S_ADDDV: begin
                    if (w_drsp.done) begin
                        r_prio[r_idx] <= w_drsp.quo;
                    end
                end
                S_AGE: begin
                    if (r_stat[r_idx] != ST_FREE && w_late) begin
                        if (r_late[r_idx] != LATE_MAX) begin
                            r_late[r_idx] <= r_late[r_idx] + 16'd1;
                        end
                        if (r_stat[r_idx] == ST_WAIT) begin
                            r_cur[r_idx]  <= w_cdec;
                            r_kept[r_idx] <= (r_kept[r_idx] != 12'd0) ?
                                             r_kept[r_idx] - 12'd1 : 12'd0;
                            r_divgo       <= 1'b1;
                        end else if (r_cur[r_idx] == 12'd0) begin
                            r_stat[r_idx] <= ST_FREE;
                            if (int'(r_idx) < 16) r_rsp.missed_mask[4'(r_idx)] <= 1'b1;
                        end
                    end
                    if (!(r_stat[r_idx] == ST_WAIT && w_late)) begin
                        r_idx <= w_last ? '0 : r_idx + SW'(1);
                    end
                end
                S_AGEDV: begin
                    if (w_drsp.done) begin
                        r_prio[r_idx] <= w_drsp.quo;
                        if (r_cur[r_idx] == 12'd0) begin
                            r_stat[r_idx] <= ST_FREE;
                            if (int'(r_idx) < 16) r_rsp.missed_mask[4'(r_idx)] <= 1'b1;
                        end
                        r_idx <= w_last ? '0 : r_idx + SW'(1);
                    end
                end
                S_SEL: begin
                    if (r_stat[r_idx] != ST_FREE &&
                        (!r_found || r_prio[r_idx] > r_bprio)) begin
                        r_found <= 1'b1;
                        r_best  <= r_idx;
                        r_bprio <= r_prio[r_idx];
                    end
                    r_idx <= w_last ? '0 : r_idx + SW'(1);
                end
                S_PRE: begin
                    if (r_found) begin
                        r_rsp.ran      <= 1'b1;
                        r_rsp.run_slot <= 4'(r_best);
                        if (r_stat[r_best] != ST_RUN) begin
                            for (int s = 0; s < SLOTS; s++) begin
                                if (r_stat[s] == ST_RUN) begin
                                    r_stat[s]       <= ST_WAIT;
                                    r_rsp.preempted <= 1'b1;
                                end
                            end
                            r_stat[r_best] <= ST_RUN;
                        end
                    end
                end
                S_RUN: begin
                    if (r_late[r_best] != 16'd0) begin
                        r_cur[r_best] <= w_cinc;
                        r_divgo       <= 1'b1;
                    end
                    if (r_rem[r_best] <= 12'd1) begin
                        r_rem[r_best]         <= 12'd0;
                        r_stat[r_best]        <= ST_FREE;
                        r_rsp.completed       <= 1'b1;
                        r_rsp.delivered_value <= r_kept[r_best];
                        r_rsp.lateness        <= r_late[r_best];
                    end else begin
                        r_rem[r_best] <= r_rem[r_best] - 12'd1;
                    end
                end
                S_RUNDV: begin
                    if (w_drsp.done) begin
                        r_prio[r_best] <= w_drsp.quo;
                    end
                end
                S_OUT: begin
                    r_done <= 1'b1;
                    if (r_req.req_type == REQ_TICK) begin
                        r_now <= r_now + 32'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_busy = (r_st != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

`ifndef NO_ASSERTIONS
    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result shown twice");
    a_done_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_st == S_OUT))
        else $error("result without finish");
    a_kind_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_rsp.accepted && o_rsp.ran))
        else $error("add and tick fields mixed");
    a_one_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_RUN) |-> (r_stat[r_best] == ST_RUN))
        else $error("selected slot not running");
`endif

endmodule

// ----- hw/rtl/vdts_density.sv -----
// ----------------------------------------------------------------------------
// vdts_density
// Priority unit: val*100000 / rem^2, restoring divide, one bit per cycle.
// ----------------------------------------------------------------------------
module vdts_density
    import vdts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int NB = 29;   // val*100000 < 2^29

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_MUL  = 4'b0010,
        D_DIV  = 4'b0100,
        D_DONE = 4'b1000
    } t_dst;

    t_dst        r_st, n_st;
    logic [23:0] r_den, n_den;
    logic [28:0] r_num, n_num;
    logic [28:0] r_quo, n_quo;
    logic [24:0] r_rmd, n_rmd;
    logic [4:0]  r_cnt, n_cnt;
    logic [11:0] r_val, n_val;
    logic [11:0] r_rem, n_rem;
    logic [24:0] w_trial;

    always_comb begin
        w_trial = {r_rmd[23:0], r_num[NB-1]};
    end

    always_comb begin
        n_st  = r_st;
        n_den = r_den;
        n_num = r_num;
        n_quo = r_quo;
        n_rmd = r_rmd;
        n_cnt = r_cnt;
        n_val = r_val;
        n_rem = r_rem;
        case (r_st)
            D_IDLE: begin
                if (i_req.start) begin
                    n_val = i_req.val;
                    n_rem = i_req.rem;
                    n_st  = D_MUL;
                end
            end
            D_MUL: begin
                n_den = (r_rem == 12'd0) ? 24'd1 : 24'(r_rem) * 24'(r_rem);
                n_num = 29'(r_val) * 29'(PRIO_SCALE);
                n_rmd = '0;
                n_quo = '0;
                n_cnt = 5'(NB - 1);
                n_st  = D_DIV;
            end
            D_DIV: begin
                if (w_trial >= {1'b0, r_den}) begin
                    n_rmd = w_trial - {1'b0, r_den};
                    n_quo = {r_quo[NB-2:0], 1'b1};
                end else begin
                    n_rmd = w_trial;
                    n_quo = {r_quo[NB-2:0], 1'b0};
                end
                n_num = {r_num[NB-2:0], 1'b0};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_st = D_DONE;
                end
            end
            D_DONE: begin
                n_st = D_IDLE;
            end
            default: begin
                n_st = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= D_IDLE;
        end else begin
            r_st <= n_st;
        end
        r_den <= n_den;
        r_num <= n_num;
        r_quo <= n_quo;
        r_rmd <= n_rmd;
        r_cnt <= n_cnt;
        r_val <= n_val;
        r_rem <= n_rem;
    end

    assign o_rsp.done = (r_st == D_DONE);
    assign o_rsp.quo  = r_quo;

`ifndef NO_ASSERTIONS
    a_done_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == D_DONE) |-> $past(r_st == D_DIV))
        else $error("done without divide");
    a_rmd_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == D_DONE) |-> (r_rmd < {1'b0, r_den}))
        else $error("remainder not reduced");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == D_MUL) |=> (r_st == D_DIV))
        else $error("bad sequence");
`endif

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Bench for the value density task scheduler: directed adds and ticks, then
// random traffic, every result checked against an in-bench scheduler model.
// ----------------------------------------------------------------------------
module tb_top;
    import vdts_pkg::*;

    localparam int NSLOT = 16;
    localparam int LIMIT = 4000000;

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    t_req i_req;
    logic o_busy;
    logic o_done;
    t_rsp o_rsp;

    value_density_task_scheduler_core #(.SLOTS(NSLOT)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_req(i_req),
        .o_busy(o_busy), .o_done(o_done), .o_rsp(o_rsp)
    );

    // scheduler state mirror
    t_slot_st    sl_st[NSLOT];
    logic [11:0] sl_val[NSLOT];
    logic [11:0] sl_kept[NSLOT];
    logic [11:0] sl_rem[NSLOT];
    logic [31:0] sl_due[NSLOT];
    logic [15:0] sl_late[NSLOT];
    logic [28:0] sl_prio[NSLOT];
    logic [31:0] tick_now;

    t_rsp rsp_q[$];
    int   errors = 0;
    int   cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [28:0] value_density(logic [11:0] v, logic [11:0] r);
        logic [63:0] sq;
        sq = r * r;
        if (sq == 0) sq = 1;
        return 29'((64'(v) * 64'd100000) / sq);
    endfunction

    function automatic t_rsp schedule_step(t_req rq);
        t_rsp r;
        int best;
        logic [11:0] len;
        r = '0;
        best = -1;
        if (rq.req_type == REQ_ADD) begin
            for (int s = 0; s < NSLOT; s++) begin
                if (sl_st[s] == ST_FREE) begin
                    len = (rq.exec_time == 0) ? 12'd1 : rq.exec_time;
                    sl_st[s] = ST_WAIT;
                    sl_val[s] = rq.task_value;
                    sl_kept[s] = rq.task_value;
                    sl_rem[s] = len;
                    sl_due[s] = rq.deadline;
                    sl_late[s] = '0;
                    sl_prio[s] = value_density(rq.task_value, len);
                    r.accepted = 1'b1;
                    r.add_slot = 4'(s);
                    break;
                end
            end
        end else begin
            for (int s = 0; s < NSLOT; s++) begin
                if (sl_st[s] == ST_FREE || !(tick_now > sl_due[s])) continue;
                if (sl_st[s] == ST_WAIT) begin
                    if (sl_val[s] > 0) sl_val[s]--;
                    if (sl_kept[s] > 0) sl_kept[s]--;
                    sl_prio[s] = value_density(sl_val[s], sl_rem[s]);
                end
                if (sl_late[s] != LATE_MAX) sl_late[s]++;
                if (sl_val[s] == 0) begin
                    sl_st[s] = ST_FREE;
                    r.missed_mask[s] = 1'b1;
                end
            end
            for (int s = 0; s < NSLOT; s++) begin
                if (sl_st[s] == ST_FREE) continue;
                if (best < 0 || sl_prio[s] > sl_prio[best]) best = s;
            end
            if (best >= 0) begin
                r.ran = 1'b1;
                r.run_slot = 4'(best);
                if (sl_st[best] != ST_RUN) begin
                    for (int s = 0; s < NSLOT; s++) begin
                        if (sl_st[s] == ST_RUN) begin
                            sl_st[s] = ST_WAIT;
                            r.preempted = 1'b1;
                        end
                    end
                    sl_st[best] = ST_RUN;
                end
                if (sl_late[best] > 0) begin
                    if (sl_val[best] != VAL_MAX) sl_val[best]++;
                    sl_prio[best] = value_density(sl_val[best], sl_rem[best]);
                end
                if (sl_rem[best] > 0) sl_rem[best]--;
                if (sl_rem[best] == 0) begin
                    sl_st[best] = ST_FREE;
                    r.completed = 1'b1;
                    r.delivered_value = sl_kept[best];
                    r.lateness = sl_late[best];
                end
            end
            tick_now++;
        end
        return r;
    endfunction

    task automatic send_req(logic kind, logic [11:0] v, logic [11:0] e, logic [31:0] d);
        t_req rq;
        t_rsp expd;
        int gap;
        rq.req_type = kind;
        rq.task_value = v;
        rq.exec_time = e;
        rq.deadline = d;
        gap = $urandom_range(0, 7);
        repeat (gap) @(posedge i_clk);
        i_start <= 1'b1;
        i_req <= rq;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        expd = schedule_step(rq);
        rsp_q = {rsp_q, expd};
        i_start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_add(logic [11:0] v, logic [11:0] e, logic [31:0] d);
        send_req(REQ_ADD, v, e, d);
    endtask

    task automatic send_tick();
        send_req(REQ_TICK, 12'($urandom), 12'($urandom), $urandom);
    endtask

    task automatic drain();
        while (rsp_q.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_rsp x;
        if (i_rst_n && o_done) begin
            if (rsp_q.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                x = rsp_q.pop_front();
                if (o_rsp.accepted !== x.accepted) begin
                    $error("accepted exp %0d got %0d", x.accepted, o_rsp.accepted); errors++;
                end
                if (o_rsp.add_slot !== x.add_slot) begin
                    $error("add_slot exp %0d got %0d", x.add_slot, o_rsp.add_slot); errors++;
                end
                if (o_rsp.ran !== x.ran) begin
                    $error("ran exp %0d got %0d", x.ran, o_rsp.ran); errors++;
                end
                if (o_rsp.run_slot !== x.run_slot) begin
                    $error("run_slot exp %0d got %0d", x.run_slot, o_rsp.run_slot); errors++;
                end
                if (o_rsp.preempted !== x.preempted) begin
                    $error("preempted exp %0d got %0d", x.preempted, o_rsp.preempted); errors++;
                end
                if (o_rsp.completed !== x.completed) begin
                    $error("completed exp %0d got %0d", x.completed, o_rsp.completed); errors++;
                end
                if (o_rsp.delivered_value !== x.delivered_value) begin
                    $error("delivered_value exp %0d got %0d", x.delivered_value,
                        o_rsp.delivered_value); errors++;
                end
                if (o_rsp.lateness !== x.lateness) begin
                    $error("lateness exp %0d got %0d", x.lateness, o_rsp.lateness); errors++;
                end
                if (o_rsp.missed_mask !== x.missed_mask) begin
                    $error("missed_mask exp %h got %h", x.missed_mask, o_rsp.missed_mask);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // corners: empty tick, zero exec time, full table, extremes, ties
    task automatic test_directed();
        send_tick();
        send_add(12'd0, 12'd0, 32'd0);
        send_add(12'hfff, 12'hfff, 32'hffffffff);
        for (int i = 0; i < 15; i++) send_add(12'd100, 12'd4, 32'd3);
        send_tick();
        send_tick();
        send_tick();
        send_tick();
        send_tick();
        send_tick();
    endtask

    // a long run of ticks, then wait for every expected result, leaving time for the late slow path
    task automatic test_drain_table();
        int n;
        n = 0;
        while (n < 300) begin
            send_tick();
            n++;
        end
        drain();
    endtask

    // mostly short tasks with near deadlines so lateness, drops and preemption occur
    task automatic test_random(int n_items);
        logic [11:0] v, e;
        logic [31:0] d;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 99) < 35) begin
                v = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40));
                e = ($urandom_range(0, 19) == 0) ? 12'($urandom) : 12'($urandom_range(0, 12));
                case ($urandom_range(0, 3))
                    0: d = $urandom;
                    1: d = tick_now - $urandom_range(0, 10);
                    default: d = tick_now + $urandom_range(0, 20);
                endcase
                send_add(v, e, d);
            end else begin
                send_tick();
            end
            if (i == n_items / 2) drain();
        end
    endtask

    initial begin
        i_start = 1'b0;
        i_req = '0;
        i_rst_n = 1'b0;
        tick_now = '0;
        for (int s = 0; s < NSLOT; s++) sl_st[s] = ST_FREE;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_drain_table();
        test_random(1200);
        drain();
        repeat (200) @(posedge i_clk);
        if (errors == 0 && rsp_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
